// ===== sv/rpid_pkg.sv =====
// Shared types and constants for the three-axis rate PID block.
// Holds the request payload structs, config register map, and controller step codes.
// No dependencies; every other file refers to it by scoped names.
package rpid_pkg;

    // Fixed field widths
    localparam int SAMPLE_WIDTH    = 16;
    localparam int LIMIT_WIDTH     = 16;
    localparam int GAIN_WIDTH      = 16;
    localparam int ALPHA_WIDTH     = 16;
    localparam int CFG_DATA_WIDTH  = 3 * GAIN_WIDTH;
    localparam int REG_INDEX_WIDTH = 3;
    localparam int NUM_AXES        = 3;
    localparam int AXIS_WIDTH      = 2;

    // Defaults for the top-level parameters
    localparam int ACC_WIDTH_DEF      = 32;
    localparam int GAIN_FRAC_BITS_DEF = 8;

    // Smoothing coefficient that means "no filtering"
    localparam logic [ALPHA_WIDTH-1:0] ALPHA_ONE = {ALPHA_WIDTH{1'b1}};

    // Axis codes
    localparam logic [AXIS_WIDTH-1:0] AXIS_ROLL  = 2'd0;
    localparam logic [AXIS_WIDTH-1:0] AXIS_PITCH = 2'd1;
    localparam logic [AXIS_WIDTH-1:0] AXIS_YAW   = 2'd2;

    // Config register reset values
    localparam logic signed [LIMIT_WIDTH-1:0] LIMIT_MAX = 16'sh7FFF;
    localparam logic signed [LIMIT_WIDTH-1:0] LIMIT_MIN = 16'sh8000;

    // Config register indexes
    typedef enum logic [REG_INDEX_WIDTH-1:0] {
        REG_ROLL_GAINS,
        REG_PITCH_GAINS,
        REG_YAW_GAINS,
        REG_INTEGRAL_UPPER,
        REG_INTEGRAL_LOWER,
        REG_DRIVE_UPPER,
        REG_DRIVE_LOWER,
        REG_DERIV_SMOOTHING
    } reg_index_t;

    // Input request payload
    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] roll_target;
        logic signed [SAMPLE_WIDTH-1:0] pitch_target;
        logic signed [SAMPLE_WIDTH-1:0] yaw_target;
        logic signed [SAMPLE_WIDTH-1:0] roll_rate;
        logic signed [SAMPLE_WIDTH-1:0] pitch_rate;
        logic signed [SAMPLE_WIDTH-1:0] yaw_rate;
    } in_item_t;

    // Output request payload
    typedef struct packed {
        logic signed [LIMIT_WIDTH-1:0] roll_drive;
        logic signed [LIMIT_WIDTH-1:0] pitch_drive;
        logic signed [LIMIT_WIDTH-1:0] yaw_drive;
    } out_item_t;

    // Config register bank; gains[axis] packs kd, ki, kp from msb down
    typedef struct packed {
        logic [NUM_AXES-1:0][CFG_DATA_WIDTH-1:0] gains;
        logic signed [LIMIT_WIDTH-1:0]           integral_upper;
        logic signed [LIMIT_WIDTH-1:0]           integral_lower;
        logic signed [LIMIT_WIDTH-1:0]           drive_upper;
        logic signed [LIMIT_WIDTH-1:0]           drive_lower;
        logic [ALPHA_WIDTH-1:0]                  deriv_smoothing;
    } cfg_t;

    // Controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_P,
        S_MUL_I,
        S_MUL_D,
        S_RAW,
        S_DIFF,
        S_MUL_Q,
        S_MUL_R,
        S_FILT,
        S_SUM,
        S_SAT,
        S_LOAD
    } state_t;

    // Datapath step commands
    typedef enum logic [3:0] {
        STEP_NONE,
        STEP_P,
        STEP_I,
        STEP_D,
        STEP_RAW,
        STEP_DIFF,
        STEP_Q,
        STEP_R,
        STEP_FILT,
        STEP_SUM,
        STEP_SAT,
        STEP_LOAD
    } step_t;

    // Controller to datapath command
    typedef struct packed {
        logic                  capture;
        logic [AXIS_WIDTH-1:0] axis;
        step_t                 step;
    } ctrl_cmd_t;

endpackage

// ===== sv/rpid_regs.sv =====
// Configuration register bank for the rate PID block.
// Depends on rpid_pkg for the register map and the cfg_t struct.
module rpid_regs
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [rpid_pkg::REG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [rpid_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
    output rpid_pkg::cfg_t                        cfg
);

    rpid_pkg::cfg_t cfg_reg;
    rpid_pkg::cfg_t cfg_next;

    // Writes are always taken
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                rpid_pkg::REG_ROLL_GAINS:
                    cfg_next.gains[rpid_pkg::AXIS_ROLL] = cfg_data;
                rpid_pkg::REG_PITCH_GAINS:
                    cfg_next.gains[rpid_pkg::AXIS_PITCH] = cfg_data;
                rpid_pkg::REG_YAW_GAINS:
                    cfg_next.gains[rpid_pkg::AXIS_YAW] = cfg_data;
                rpid_pkg::REG_INTEGRAL_UPPER:
                    cfg_next.integral_upper = cfg_data[rpid_pkg::LIMIT_WIDTH-1:0];
                rpid_pkg::REG_INTEGRAL_LOWER:
                    cfg_next.integral_lower = cfg_data[rpid_pkg::LIMIT_WIDTH-1:0];
                rpid_pkg::REG_DRIVE_UPPER:
                    cfg_next.drive_upper = cfg_data[rpid_pkg::LIMIT_WIDTH-1:0];
                rpid_pkg::REG_DRIVE_LOWER:
                    cfg_next.drive_lower = cfg_data[rpid_pkg::LIMIT_WIDTH-1:0];
                rpid_pkg::REG_DERIV_SMOOTHING:
                    cfg_next.deriv_smoothing = cfg_data[rpid_pkg::ALPHA_WIDTH-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    // Register storage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gains           <= '0;
            cfg_reg.integral_upper  <= rpid_pkg::LIMIT_MAX;
            cfg_reg.integral_lower  <= rpid_pkg::LIMIT_MIN;
            cfg_reg.drive_upper     <= rpid_pkg::LIMIT_MAX;
            cfg_reg.drive_lower     <= rpid_pkg::LIMIT_MIN;
            cfg_reg.deriv_smoothing <= rpid_pkg::ALPHA_ONE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== sv/rpid_ctrl.sv =====
// Sequencing controller for the rate PID block: walks three axes through
// the shared-multiplier steps and owns the request handshakes.
// Depends on rpid_pkg for state, step and command types.
module rpid_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  logic                filter_bypass,
    output rpid_pkg::ctrl_cmd_t cmd
);

    rpid_pkg::state_t                    state_reg;
    rpid_pkg::state_t                    state_next;
    logic [rpid_pkg::AXIS_WIDTH-1:0]     axis_reg;
    logic [rpid_pkg::AXIS_WIDTH-1:0]     axis_next;
    logic                                out_valid_reg;
    logic                                out_valid_next;
    logic                                out_free;

    // Output register may be overwritten when empty or being drained
    assign out_free = !out_valid_reg || out_ready;

    // Next state, axis counter and output valid
    always_comb
    begin
        state_next     = state_reg;
        axis_next      = axis_reg;
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            rpid_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = rpid_pkg::S_MUL_P;
                    axis_next  = rpid_pkg::AXIS_ROLL;
                end
            end
            rpid_pkg::S_MUL_P: state_next = rpid_pkg::S_MUL_I;
            rpid_pkg::S_MUL_I: state_next = rpid_pkg::S_MUL_D;
            rpid_pkg::S_MUL_D: state_next = rpid_pkg::S_RAW;
            rpid_pkg::S_RAW:   state_next = rpid_pkg::S_DIFF;
            rpid_pkg::S_DIFF:
            begin
                state_next = filter_bypass ? rpid_pkg::S_SUM : rpid_pkg::S_MUL_Q;
            end
            rpid_pkg::S_MUL_Q: state_next = rpid_pkg::S_MUL_R;
            rpid_pkg::S_MUL_R: state_next = rpid_pkg::S_FILT;
            rpid_pkg::S_FILT:  state_next = rpid_pkg::S_SUM;
            rpid_pkg::S_SUM:   state_next = rpid_pkg::S_SAT;
            rpid_pkg::S_SAT:
            begin
                if (axis_reg == rpid_pkg::AXIS_YAW)
                begin
                    state_next = rpid_pkg::S_LOAD;
                end
                else
                begin
                    state_next = rpid_pkg::S_MUL_P;
                    axis_next  = axis_reg + 1'b1;
                end
            end
            rpid_pkg::S_LOAD:
            begin
                if (out_free)
                begin
                    state_next     = rpid_pkg::S_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default: state_next = rpid_pkg::S_IDLE;
        endcase
    end

    // Commands and handshake outputs
    always_comb
    begin
        in_ready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.axis    = axis_reg;
        cmd.step    = rpid_pkg::STEP_NONE;
        case (state_reg)
            rpid_pkg::S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            rpid_pkg::S_MUL_P: cmd.step = rpid_pkg::STEP_P;
            rpid_pkg::S_MUL_I: cmd.step = rpid_pkg::STEP_I;
            rpid_pkg::S_MUL_D: cmd.step = rpid_pkg::STEP_D;
            rpid_pkg::S_RAW:   cmd.step = rpid_pkg::STEP_RAW;
            rpid_pkg::S_DIFF:  cmd.step = rpid_pkg::STEP_DIFF;
            rpid_pkg::S_MUL_Q: cmd.step = rpid_pkg::STEP_Q;
            rpid_pkg::S_MUL_R: cmd.step = rpid_pkg::STEP_R;
            rpid_pkg::S_FILT:  cmd.step = rpid_pkg::STEP_FILT;
            rpid_pkg::S_SUM:   cmd.step = rpid_pkg::STEP_SUM;
            rpid_pkg::S_SAT:   cmd.step = rpid_pkg::STEP_SAT;
            rpid_pkg::S_LOAD:
            begin
                cmd.step = out_free ? rpid_pkg::STEP_LOAD : rpid_pkg::STEP_NONE;
            end
            default: cmd.step = rpid_pkg::STEP_NONE;
        endcase
    end

    assign out_valid = out_valid_reg;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rpid_pkg::S_IDLE;
            axis_reg      <= rpid_pkg::AXIS_ROLL;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== sv/rpid_dpath.sv =====
// Datapath of the rate PID block: one shared signed multiplier, the per-axis
// integrator, last error and smoothed derivative state, and the output register.
// Depends on rpid_pkg; driven step by step from rpid_ctrl.
module rpid_dpath
#(
    parameter int ACC_WIDTH      = rpid_pkg::ACC_WIDTH_DEF,
    parameter int GAIN_FRAC_BITS = rpid_pkg::GAIN_FRAC_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  rpid_pkg::ctrl_cmd_t cmd,
    input  rpid_pkg::in_item_t  in_data,
    input  rpid_pkg::cfg_t      cfg,
    output logic                filter_bypass,
    output rpid_pkg::out_item_t out_data
);

    localparam int SW    = rpid_pkg::SAMPLE_WIDTH;
    localparam int LW    = rpid_pkg::LIMIT_WIDTH;
    localparam int GW    = rpid_pkg::GAIN_WIDTH;
    localparam int AW    = rpid_pkg::ALPHA_WIDTH;
    localparam int ERR_W = SW + 1;
    localparam int DIF_W = SW + 2;
    localparam int DW    = ACC_WIDTH + 1;
    localparam int Q_W   = DW - AW;
    localparam int MA    = (Q_W > DIF_W) ? Q_W : DIF_W;
    localparam int MB    = AW + 1;
    localparam int PW    = MA + MB;
    localparam int SUMW  = PW + 1;
    localparam int INT_W = LW + GAIN_FRAC_BITS;
    localparam int NAX   = rpid_pkg::NUM_AXES;

    // Payload registers
    rpid_pkg::in_item_t          item_reg, item_next;
    logic signed [PW-1:0]        prod_reg, prod_next;
    logic signed [PW-1:0]        part_reg, part_next;
    logic signed [ACC_WIDTH-1:0] raw_reg, raw_next;
    logic signed [DW-1:0]        d_reg, d_next;
    logic signed [SUMW-1:0]      sum_reg, sum_next;
    logic signed [LW-1:0]        drive_reg [NAX];
    logic signed [LW-1:0]        drive_next [NAX];
    rpid_pkg::out_item_t         out_reg, out_next;

    // Per-axis controller state
    logic signed [INT_W-1:0]     integ_reg [NAX];
    logic signed [INT_W-1:0]     integ_next [NAX];
    logic signed [ERR_W-1:0]     last_err_reg [NAX];
    logic signed [ERR_W-1:0]     last_err_next [NAX];
    logic signed [ACC_WIDTH-1:0] smooth_reg [NAX];
    logic signed [ACC_WIDTH-1:0] smooth_next [NAX];

    logic signed [SW-1:0]        tgt;
    logic signed [SW-1:0]        rt;
    logic [rpid_pkg::CFG_DATA_WIDTH-1:0] gains;
    logic signed [GW-1:0]        kp, ki, kd;
    logic signed [ERR_W-1:0]     err;
    logic signed [DIF_W-1:0]     diff;
    logic signed [Q_W-1:0]       filt_q;
    logic signed [MA-1:0]        mul_a;
    logic signed [MB-1:0]        mul_b;
    logic signed [MB-1:0]        alpha;
    logic signed [PW-1:0]        product;

    logic signed [SUMW-1:0]      integ_sum, integ_hi, integ_lo, integ_clip;
    logic signed [INT_W-1:0]     integ_new;
    logic [PW-ACC_WIDTH:0]       raw_top;
    logic                        raw_ovf;
    logic signed [ACC_WIDTH-1:0] raw_sat;
    logic signed [SUMW-1:0]      filt_sum;
    logic signed [SUMW-1:0]      drive_shift, drive_hi, drive_lo, drive_clip;
    logic signed [LW-1:0]        drive_sat;

    assign filter_bypass = (cfg.deriv_smoothing == rpid_pkg::ALPHA_ONE);
    assign alpha         = $signed({1'b0, cfg.deriv_smoothing});

    // Axis operand selection
    always_comb
    begin
        case (cmd.axis)
            rpid_pkg::AXIS_ROLL:
            begin
                tgt = item_reg.roll_target;
                rt  = item_reg.roll_rate;
            end
            rpid_pkg::AXIS_PITCH:
            begin
                tgt = item_reg.pitch_target;
                rt  = item_reg.pitch_rate;
            end
            default:
            begin
                tgt = item_reg.yaw_target;
                rt  = item_reg.yaw_rate;
            end
        endcase
    end

    assign gains = cfg.gains[cmd.axis];
    assign kp    = $signed(gains[GW-1:0]);
    assign ki    = $signed(gains[2*GW-1:GW]);
    assign kd    = $signed(gains[3*GW-1:2*GW]);

    // Error and error change
    assign err    = ERR_W'(tgt) - ERR_W'(rt);
    assign diff   = DIF_W'(err) - DIF_W'(last_err_reg[cmd.axis]);
    assign filt_q = $signed(d_reg[DW-1:AW]);

    // Shared multiplier operand mux
    always_comb
    begin
        case (cmd.step)
            rpid_pkg::STEP_P:
            begin
                mul_a = MA'(err);
                mul_b = MB'(kp);
            end
            rpid_pkg::STEP_I:
            begin
                mul_a = MA'(err);
                mul_b = MB'(ki);
            end
            rpid_pkg::STEP_D:
            begin
                mul_a = MA'(diff);
                mul_b = MB'(kd);
            end
            rpid_pkg::STEP_Q:
            begin
                mul_a = MA'(filt_q);
                mul_b = alpha;
            end
            rpid_pkg::STEP_R:
            begin
                mul_a = MA'($signed({1'b0, d_reg[AW-1:0]}));
                mul_b = alpha;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign product = mul_a * mul_b;

    // Integrator update with clamp: upper limit first, then lower
    always_comb
    begin
        integ_sum  = SUMW'(integ_reg[cmd.axis]) + SUMW'(prod_reg);
        integ_hi   = SUMW'(cfg.integral_upper) <<< GAIN_FRAC_BITS;
        integ_lo   = SUMW'(cfg.integral_lower) <<< GAIN_FRAC_BITS;
        integ_clip = integ_sum;
        if (integ_clip > integ_hi)
        begin
            integ_clip = integ_hi;
        end
        if (integ_clip < integ_lo)
        begin
            integ_clip = integ_lo;
        end
        integ_new = integ_clip[INT_W-1:0];
    end

    // Raw derivative saturation to the accumulator range
    assign raw_top = prod_reg[PW-1:ACC_WIDTH-1];
    assign raw_ovf = !((&raw_top) || !(|raw_top));
    always_comb
    begin
        if (raw_ovf)
        begin
            raw_sat = prod_reg[PW-1] ? {1'b1, {(ACC_WIDTH-1){1'b0}}}
                                     : {1'b0, {(ACC_WIDTH-1){1'b1}}};
        end
        else
        begin
            raw_sat = prod_reg[ACC_WIDTH-1:0];
        end
    end

    // Filter step: smoothed + q*a + floor(r*a / 2^16)
    assign filt_sum = SUMW'(smooth_reg[cmd.axis]) + SUMW'(part_reg)
                    + SUMW'(prod_reg >>> AW);

    // Output scaling (floor) and drive saturation
    always_comb
    begin
        drive_shift = sum_reg >>> GAIN_FRAC_BITS;
        drive_hi    = SUMW'(cfg.drive_upper);
        drive_lo    = SUMW'(cfg.drive_lower);
        drive_clip  = drive_shift;
        if (drive_clip > drive_hi)
        begin
            drive_clip = drive_hi;
        end
        if (drive_clip < drive_lo)
        begin
            drive_clip = drive_lo;
        end
        drive_sat = drive_clip[LW-1:0];
    end

    // Step execution
    always_comb
    begin
        item_next     = item_reg;
        prod_next     = prod_reg;
        part_next     = part_reg;
        raw_next      = raw_reg;
        d_next        = d_reg;
        sum_next      = sum_reg;
        drive_next    = drive_reg;
        out_next      = out_reg;
        integ_next    = integ_reg;
        last_err_next = last_err_reg;
        smooth_next   = smooth_reg;
        if (cmd.capture)
        begin
            item_next = in_data;
        end
        case (cmd.step)
            rpid_pkg::STEP_P:
            begin
                prod_next = product;
            end
            rpid_pkg::STEP_I:
            begin
                prod_next = product;
                sum_next  = SUMW'(prod_reg);
            end
            rpid_pkg::STEP_D:
            begin
                prod_next            = product;
                integ_next[cmd.axis] = integ_new;
            end
            rpid_pkg::STEP_RAW:
            begin
                raw_next                = raw_sat;
                sum_next                = sum_reg + SUMW'(integ_reg[cmd.axis]);
                last_err_next[cmd.axis] = err;
            end
            rpid_pkg::STEP_DIFF:
            begin
                if (filter_bypass)
                begin
                    smooth_next[cmd.axis] = raw_reg;
                end
                else
                begin
                    d_next = DW'(raw_reg) - DW'(smooth_reg[cmd.axis]);
                end
            end
            rpid_pkg::STEP_Q:
            begin
                prod_next = product;
            end
            rpid_pkg::STEP_R:
            begin
                prod_next = product;
                part_next = prod_reg;
            end
            rpid_pkg::STEP_FILT:
            begin
                smooth_next[cmd.axis] = filt_sum[ACC_WIDTH-1:0];
            end
            rpid_pkg::STEP_SUM:
            begin
                sum_next = sum_reg + SUMW'(smooth_reg[cmd.axis]);
            end
            rpid_pkg::STEP_SAT:
            begin
                drive_next[cmd.axis] = drive_sat;
            end
            rpid_pkg::STEP_LOAD:
            begin
                out_next.roll_drive  = drive_reg[rpid_pkg::AXIS_ROLL];
                out_next.pitch_drive = drive_reg[rpid_pkg::AXIS_PITCH];
                out_next.yaw_drive   = drive_reg[rpid_pkg::AXIS_YAW];
            end
            default:
            begin
                prod_next = prod_reg;
            end
        endcase
    end

    // Controller state, cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NAX; i++)
            begin
                integ_reg[i]    <= '0;
                last_err_reg[i] <= '0;
                smooth_reg[i]   <= '0;
            end
        end
        else
        begin
            integ_reg    <= integ_next;
            last_err_reg <= last_err_next;
            smooth_reg   <= smooth_next;
        end
    end

    // Working and output payload registers
    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        prod_reg  <= prod_next;
        part_reg  <= part_next;
        raw_reg   <= raw_next;
        d_reg     <= d_next;
        sum_reg   <= sum_next;
        drive_reg <= drive_next;
        out_reg   <= out_next;
    end

    assign out_data = out_reg;

endmodule

// ===== sv/three_axis_rate_pid.sv =====
// Three-axis rate PID (roll, pitch, yaw) with clamped integrator, low-pass
// filtered derivative and saturated drive outputs; one drive request per
// rate request. One request is processed at a time: all multiplies go
// through a single shared signed multiplier, stepped over the three axes in
// turn, and the next request is accepted only once the current result
// has been loaded into the output register (the filter multiplies are
// skipped when deriv_smoothing is 65535). A finished result sits in the output
// register while the next request is already being worked on. Configuration
// writes are taken every cycle and must only be issued while the block is idle.
module three_axis_rate_pid
#(
    parameter int ACC_WIDTH      = rpid_pkg::ACC_WIDTH_DEF,
    parameter int GAIN_FRAC_BITS = rpid_pkg::GAIN_FRAC_BITS_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  rpid_pkg::in_item_t                   in_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output rpid_pkg::out_item_t                  out_data,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [rpid_pkg::REG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [rpid_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);

    rpid_pkg::cfg_t      cfg;
    rpid_pkg::ctrl_cmd_t cmd;
    logic                filter_bypass;

    // Configuration registers
    rpid_regs u_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Step sequencer
    rpid_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .filter_bypass (filter_bypass),
        .cmd           (cmd)
    );

    // Arithmetic and state
    rpid_dpath
    #(
        .ACC_WIDTH      (ACC_WIDTH),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    )
    u_dpath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .in_data       (in_data),
        .cfg           (cfg),
        .filter_bypass (filter_bypass),
        .out_data      (out_data)
    );

endmodule
